// ----- rtl/core/alr_pkg.sv -----
// Shared types and constants for the antialiased line rasterizer.
`default_nettype none

package alr_pkg;

   // Configuration register file
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_COLOR     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTENSITY_BITS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_LEVELS     = 2'd2;

   localparam int BASE_COLOR_BITS = 8;
   localparam int INTEN_SEL_BITS  = 4;
   localparam int LEVELS_BITS     = 9;
   localparam int INTENSITY_BITS  = 9;

   localparam logic [INTENSITY_BITS-1:0] INTENSITY_MAX = '1;

   typedef struct packed {
      logic [BASE_COLOR_BITS-1:0] base_color;
      logic [INTEN_SEL_BITS-1:0]  intensity_bits;
      logic [LEVELS_BITS-1:0]     num_levels;
   } alr_cfg_type;

   localparam alr_cfg_type CFG_RESET = '{
      base_color:     8'd0,
      intensity_bits: 4'd8,
      num_levels:     9'd256
   };

   // Line class decided by the front end
   typedef enum logic [1:0] {
      LK_STRAIGHT,
      LK_YMAJOR,
      LK_XMAJOR
   } line_kind_type;

   // Command word: kind, xneg, stepx, stepy, x0, y0, x1, y1, major, minor
   localparam int CMD_FLAG_BITS = $bits(line_kind_type) + 3;

endpackage

`default_nettype wire

// ----- rtl/core/alr_if.sv -----
// Request and response channel interfaces of the line rasterizer.
`default_nettype none

interface alr_req_if #(
   parameter int COORD_BITS = 5
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] x_start;
   logic [COORD_BITS-1:0] y_start;
   logic [COORD_BITS-1:0] x_end;
   logic [COORD_BITS-1:0] y_end;

   modport source (output valid, output x_start, output y_start, output x_end,
                   output y_end, input ready);
   modport sink (input valid, input x_start, input y_start, input x_end,
                 input y_end, output ready);
endinterface

interface alr_rsp_if
   import alr_pkg::*;
#(
   parameter int COORD_BITS = 5
) ();
   logic                      valid;
   logic                      ready;
   logic [COORD_BITS-1:0]     pixel_x;
   logic [COORD_BITS-1:0]     pixel_y;
   logic [INTENSITY_BITS-1:0] intensity;
   logic                      last;

   modport source (output valid, output pixel_x, output pixel_y, output intensity,
                   output last, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input intensity,
                 input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/alr_queue.sv -----
// Small FIFO of classified line commands between front and back end.
`default_nettype none

module alr_queue
   import alr_pkg::*;
#(
   parameter int WIDTH = 35,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop_fire) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         if (push_fire && !pop_fire) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop_fire && !push_fire) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/alr_front.sv -----
// Front end: orders the endpoints top to bottom and classifies the line.
`default_nettype none

module alr_front
   import alr_pkg::*;
#(
   parameter int COORD_BITS = 5,
   parameter int CMD_W      = 6 * COORD_BITS + CMD_FLAG_BITS
) (
   alr_req_if.sink           req_bus,
   output logic              cmd_valid,
   input  wire logic         cmd_ready,
   output logic [CMD_W-1:0]  cmd_data
);

   logic                  swap;
   logic [COORD_BITS-1:0] x0;
   logic [COORD_BITS-1:0] y0;
   logic [COORD_BITS-1:0] x1;
   logic [COORD_BITS-1:0] y1;
   logic                  xneg;
   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;
   logic                  straight;
   logic                  ymajor;
   line_kind_type         kind;
   logic [COORD_BITS-1:0] major;
   logic [COORD_BITS-1:0] minor;

   assign swap = req_bus.y_start > req_bus.y_end;
   assign x0   = swap ? req_bus.x_end   : req_bus.x_start;
   assign y0   = swap ? req_bus.y_end   : req_bus.y_start;
   assign x1   = swap ? req_bus.x_start : req_bus.x_end;
   assign y1   = swap ? req_bus.y_start : req_bus.y_end;

   assign xneg = x1 < x0;
   assign dx   = xneg ? x0 - x1 : x1 - x0;
   assign dy   = y1 - y0;

   assign straight = (dy == '0) || (dx == '0) || (dx == dy);
   assign ymajor   = dy > dx;
   assign kind     = straight ? LK_STRAIGHT : (ymajor ? LK_YMAJOR : LK_XMAJOR);
   // for straight lines major is the pixel count minus one
   assign major    = ymajor ? dy : dx;
   assign minor    = ymajor ? dx : dy;

   assign cmd_valid     = req_bus.valid;
   assign req_bus.ready = cmd_ready;
   assign cmd_data      = {kind, xneg, (dx != '0), (dy != '0), x0, y0, x1, y1, major, minor};

endmodule

`default_nettype wire

// ----- rtl/core/alr_back.sv -----
// Back end: setup divider, Wu stepping and the response output register.
`default_nettype none

module alr_back
   import alr_pkg::*;
#(
   parameter int COORD_BITS = 5,
   parameter int FRAC_BITS  = 16,
   parameter int CMD_W      = 6 * COORD_BITS + CMD_FLAG_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire alr_cfg_type      cfg,
   input  wire logic             cmd_valid,
   output logic                  cmd_ready,
   input  wire logic [CMD_W-1:0] cmd_data,
   alr_rsp_if.source             rsp_bus
);

   localparam int C      = COORD_BITS;
   localparam int SH_W   = $clog2(FRAC_BITS + 1);
   localparam int SUM_W  = ((FRAC_BITS > INTENSITY_BITS) ? FRAC_BITS : INTENSITY_BITS) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LINE,
      S_DIV,
      S_FIRST,
      S_MAIN,
      S_NEIGH,
      S_END
   } state_type;

   state_type             state_ff;
   line_kind_type         kind_ff;
   logic                  xneg_ff;
   logic                  stepx_ff;
   logic                  stepy_ff;
   logic [C-1:0]          x_ff;
   logic [C-1:0]          y_ff;
   logic [C-1:0]          x1_ff;
   logic [C-1:0]          y1_ff;
   logic [C-1:0]          major_ff;
   logic [C-1:0]          cnt_ff;
   logic [C-1:0]          rem_ff;
   logic [SH_W-1:0]       div_cnt_ff;
   logic [FRAC_BITS-1:0]  quot_ff;
   logic [FRAC_BITS-1:0]  acc_ff;

   logic                      rsp_valid_ff;
   logic [C-1:0]              pixel_x_ff;
   logic [C-1:0]              pixel_y_ff;
   logic [INTENSITY_BITS-1:0] intensity_ff;
   logic                      last_ff;

   // command fields
   logic [$bits(line_kind_type)-1:0] cmd_kind_bits;
   line_kind_type         cmd_kind;
   logic                  cmd_xneg;
   logic                  cmd_stepx;
   logic                  cmd_stepy;
   logic [C-1:0]          cmd_x0;
   logic [C-1:0]          cmd_y0;
   logic [C-1:0]          cmd_x1;
   logic [C-1:0]          cmd_y1;
   logic [C-1:0]          cmd_major;
   logic [C-1:0]          cmd_minor;

   logic [C-1:0]          xs;
   logic [C:0]            rem_sh;
   logic                  quot_bit;
   logic [C-1:0]          rem_in;
   logic [FRAC_BITS-1:0]  acc_in;
   logic                  carry;
   logic [C-1:0]          main_x_in;
   logic [C-1:0]          main_y_in;
   logic [C-1:0]          neigh_x;
   logic [C-1:0]          neigh_y;
   logic [SH_W-1:0]       ib_sat;
   logic [SH_W-1:0]       shift;
   logic [LEVELS_BITS-1:0] cmask;
   logic [FRAC_BITS-1:0]  weight;
   logic [SUM_W-1:0]      sum_main;
   logic [SUM_W-1:0]      sum_comp;
   logic [INTENSITY_BITS-1:0] inten_main;
   logic [INTENSITY_BITS-1:0] inten_comp;
   logic [INTENSITY_BITS-1:0] inten_base;

   logic                      emit_ok;
   logic                      emit_fire;
   logic [C-1:0]              out_x_in;
   logic [C-1:0]              out_y_in;
   logic [INTENSITY_BITS-1:0] out_inten_in;
   logic                      out_last_in;

   assign {cmd_kind_bits, cmd_xneg, cmd_stepx, cmd_stepy, cmd_x0, cmd_y0, cmd_x1, cmd_y1,
           cmd_major, cmd_minor} = cmd_data;
   assign cmd_kind  = line_kind_type'(cmd_kind_bits);
   assign cmd_ready = state_ff == S_IDLE;

   assign xs = xneg_ff ? '1 : C'(1);

   // restoring division, one quotient bit per cycle; remainder stays below major
   assign rem_sh   = {rem_ff, 1'b0};
   assign quot_bit = rem_sh >= {1'b0, major_ff};
   assign rem_in   = quot_bit ? C'(rem_sh - {1'b0, major_ff}) : C'(rem_sh);

   // minor axis advances when the accumulator wraps
   assign acc_in = acc_ff + quot_ff;
   assign carry  = acc_in <= acc_ff;

   always_comb begin
      if (kind_ff == LK_YMAJOR) begin
         main_x_in = carry ? x_ff + xs : x_ff;
         main_y_in = y_ff + C'(1);
         neigh_x   = x_ff + xs;
         neigh_y   = y_ff;
      end else begin
         main_x_in = x_ff + xs;
         main_y_in = carry ? y_ff + C'(1) : y_ff;
         neigh_x   = x_ff;
         neigh_y   = y_ff + C'(1);
      end
   end

   assign ib_sat = (int'(cfg.intensity_bits) > FRAC_BITS) ? SH_W'(FRAC_BITS)
                                                           : SH_W'(cfg.intensity_bits);
   assign shift  = SH_W'(FRAC_BITS) - ib_sat;
   assign cmask  = cfg.num_levels - LEVELS_BITS'(1);
   assign weight = ((state_ff == S_MAIN) ? acc_in : acc_ff) >> shift;

   assign sum_main = SUM_W'(cfg.base_color) + SUM_W'(weight);
   assign sum_comp = SUM_W'(cfg.base_color) + SUM_W'((SUM_W - 1)'(weight) ^ (SUM_W - 1)'(cmask));

   assign inten_main = (sum_main > SUM_W'(INTENSITY_MAX)) ? INTENSITY_MAX
                                                          : INTENSITY_BITS'(sum_main);
   assign inten_comp = (sum_comp > SUM_W'(INTENSITY_MAX)) ? INTENSITY_MAX
                                                          : INTENSITY_BITS'(sum_comp);
   assign inten_base = INTENSITY_BITS'(cfg.base_color);

   assign emit_ok = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      emit_fire    = 1'b0;
      out_x_in     = x_ff;
      out_y_in     = y_ff;
      out_inten_in = inten_base;
      out_last_in  = 1'b0;
      case (state_ff)
         S_LINE: begin
            emit_fire   = emit_ok;
            out_last_in = cnt_ff == '0;
         end
         S_FIRST: begin
            emit_fire = emit_ok;
         end
         S_MAIN: begin
            emit_fire    = emit_ok;
            out_x_in     = main_x_in;
            out_y_in     = main_y_in;
            out_inten_in = inten_main;
         end
         S_NEIGH: begin
            emit_fire    = emit_ok;
            out_x_in     = neigh_x;
            out_y_in     = neigh_y;
            out_inten_in = inten_comp;
         end
         S_END: begin
            emit_fire   = emit_ok;
            out_x_in    = x1_ff;
            out_y_in    = y1_ff;
            out_last_in = 1'b1;
         end
         default: begin
            emit_fire = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
            pixel_x_ff   <= out_x_in;
            pixel_y_ff   <= out_y_in;
            intensity_ff <= out_inten_in;
            last_ff      <= out_last_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  kind_ff    <= cmd_kind;
                  xneg_ff    <= cmd_xneg;
                  stepx_ff   <= cmd_stepx;
                  stepy_ff   <= cmd_stepy;
                  x_ff       <= cmd_x0;
                  y_ff       <= cmd_y0;
                  x1_ff      <= cmd_x1;
                  y1_ff      <= cmd_y1;
                  major_ff   <= cmd_major;
                  rem_ff     <= cmd_minor;
                  div_cnt_ff <= SH_W'(FRAC_BITS);
                  if (cmd_kind == LK_STRAIGHT) begin
                     cnt_ff   <= cmd_major;
                     state_ff <= S_LINE;
                  end else begin
                     cnt_ff   <= cmd_major - C'(1);
                     state_ff <= S_DIV;
                  end
               end
            end
            S_LINE: begin
               if (emit_ok) begin
                  if (cnt_ff == '0) begin
                     state_ff <= S_IDLE;
                  end else begin
                     x_ff   <= stepx_ff ? x_ff + xs : x_ff;
                     y_ff   <= y_ff + C'(stepy_ff);
                     cnt_ff <= cnt_ff - C'(1);
                  end
               end
            end
            S_DIV: begin
               rem_ff     <= rem_in;
               quot_ff    <= {quot_ff[FRAC_BITS-2:0], quot_bit};
               div_cnt_ff <= div_cnt_ff - SH_W'(1);
               if (div_cnt_ff == SH_W'(1)) begin
                  state_ff <= S_FIRST;
               end
            end
            S_FIRST: begin
               if (emit_ok) begin
                  acc_ff   <= '0;
                  state_ff <= S_MAIN;
               end
            end
            S_MAIN: begin
               if (emit_ok) begin
                  acc_ff   <= acc_in;
                  x_ff     <= main_x_in;
                  y_ff     <= main_y_in;
                  state_ff <= S_NEIGH;
               end
            end
            S_NEIGH: begin
               if (emit_ok) begin
                  cnt_ff   <= cnt_ff - C'(1);
                  state_ff <= (cnt_ff == C'(1)) ? S_END : S_MAIN;
               end
            end
            S_END: begin
               if (emit_ok) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pixel_x   = pixel_x_ff;
   assign rsp_bus.pixel_y   = pixel_y_ff;
   assign rsp_bus.intensity = intensity_ff;
   assign rsp_bus.last      = last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/antialiased_line_rasterizer.sv -----
// Top level of the antialiased line rasterizer.
// Each request carries two endpoints; the block returns the line's pixels in
// Wu's antialiased style, one response per pixel, the final one with last set.
// A front end classifies the request and parks it in a two-entry command queue,
// so new requests are taken while the back end is still drawing. Horizontal,
// vertical and diagonal lines are stepped directly. Other lines first run the
// setup division in the back end, which retires one quotient bit per cycle;
// then the pixel stepper emits one pixel per cycle through the response
// register, unless response back-pressure stalls it. Configuration registers
// are written through the csr port; the user must write them only while the
// block is idle, and the block itself does not enforce this.
`default_nettype none

module antialiased_line_rasterizer
   import alr_pkg::*;
#(
   parameter int COORD_BITS  = 5,
   parameter int FRAC_BITS   = 16,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   alr_req_if.sink                        req_bus,
   alr_rsp_if.source                      rsp_bus,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CMD_W = 6 * COORD_BITS + CMD_FLAG_BITS;

   alr_cfg_type      cfg_ff;
   alr_cfg_type      cfg_in;
   logic             push_valid;
   logic             push_ready;
   logic [CMD_W-1:0] push_data;
   logic             pop_valid;
   logic             pop_ready;
   logic [CMD_W-1:0] pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      case (csr_index)
         CSR_BASE_COLOR:     cfg_in.base_color     = csr_wdata[BASE_COLOR_BITS-1:0];
         CSR_INTENSITY_BITS: cfg_in.intensity_bits = csr_wdata[INTEN_SEL_BITS-1:0];
         CSR_NUM_LEVELS:     cfg_in.num_levels     = csr_wdata[LEVELS_BITS-1:0];
         default:            cfg_in = cfg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         cfg_ff <= cfg_in;
      end
   end

   alr_front #(
      .COORD_BITS (COORD_BITS),
      .CMD_W      (CMD_W)
   ) u_front (
      .req_bus   (req_bus),
      .cmd_valid (push_valid),
      .cmd_ready (push_ready),
      .cmd_data  (push_data)
   );

   alr_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   alr_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .CMD_W      (CMD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd_data  (pop_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- rtl/core/alr_checker.sv -----
// Port-level checks on the rasterizer response stream, bound to the top level.
`default_nettype none

module alr_checker #(
   parameter int COORD_BITS = 5
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [COORD_BITS-1:0] pixel_x,
   input wire logic [COORD_BITS-1:0] pixel_y,
   input wire logic [8:0]            intensity,
   input wire logic                  last
);

   logic                  in_line_ff;
   logic [COORD_BITS-1:0] prev_x_ff;
   logic [COORD_BITS-1:0] prev_y_ff;
   logic                  xfer;
   logic [COORD_BITS-1:0] step_x;
   logic [COORD_BITS-1:0] step_y;

   assign xfer   = rsp_valid && rsp_ready;
   assign step_x = pixel_x - prev_x_ff;
   assign step_y = pixel_y - prev_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_line_ff <= 1'b0;
      end else if (xfer) begin
         in_line_ff <= !last;
         prev_x_ff  <= pixel_x;
         prev_y_ff  <= pixel_y;
      end
   end

   // no response may be left pending across a reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_x) && $stable(pixel_y)
                                  && $stable(intensity) && $stable(last))
      else $error("stalled response changed");

   // successive pixels of one line touch each other
   a_adjacent_x: assert property (@(posedge clock) disable iff (reset)
      xfer && in_line_ff |-> step_x == '0 || step_x == COORD_BITS'(1) || step_x == '1)
      else $error("pixel column jumped within a line");

   a_adjacent_y: assert property (@(posedge clock) disable iff (reset)
      xfer && in_line_ff |-> step_y == '0 || step_y == COORD_BITS'(1) || step_y == '1)
      else $error("pixel row jumped within a line");

endmodule

bind antialiased_line_rasterizer alr_checker #(
   .COORD_BITS (COORD_BITS)
) u_alr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .pixel_x   (rsp_bus.pixel_x),
   .pixel_y   (rsp_bus.pixel_y),
   .intensity (rsp_bus.intensity),
   .last      (rsp_bus.last)
);

`default_nettype wire
